// File: rtl/mmc_pkg.sv
// shared constants, types and codes for the magnetometer min/max calibration block
`default_nettype none

package mmc_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int NUM_AXES        = 3;

  // unsigned Q4.x gain
  localparam int GAIN_BITS    = SCALE_FRAC_BITS + 4;
  // sum of three ranges, and three times one range
  localparam int TOT_BITS     = SAMPLE_BITS + 2;
  localparam int DEN_BITS     = SAMPLE_BITS + 2;
  // total shifted up by the fraction bits
  localparam int DVD_BITS     = TOT_BITS + SCALE_FRAC_BITS;
  localparam int DIFF_BITS    = SAMPLE_BITS + 1;
  localparam int PROD_BITS    = DIFF_BITS + GAIN_BITS + 1;
  localparam int SHR_BITS     = PROD_BITS - SCALE_FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        range_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [TOT_BITS-1:0]           total_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam gain_t   GAIN_MAX   = {GAIN_BITS{1'b1}};
  localparam gain_t   GAIN_ONE   = {{(GAIN_BITS-SCALE_FRAC_BITS-1){1'b0}}, 1'b1,
                                    {SCALE_FRAC_BITS{1'b0}}};
  localparam gain_t   GAIN_ZERO  = {GAIN_BITS{1'b0}};

  // input op codes
  localparam logic OP_CAL   = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // result kind codes
  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_CORR = 1'b1;

  // controls broadcast to every lane
  typedef struct packed {
    logic cal;         // fold a calibration sample into min/max
    logic apply;       // latch sample minus offset
    logic rng_load;    // latch range and offset, re-arm min/max
    logic div_start;   // load the divider from the merged total
    logic div_step;    // one quotient bit
    logic scale_load;  // commit the new scale
    logic mul_load;    // register the correction product
  } lane_ctrl_t;

  // what one lane reports back to the merge stage
  typedef struct packed {
    range_t  rng;
    sample_t off;
    gain_t   scale;
    logic    cal_err;
    sample_t corr;
    logic    corr_err;
  } lane_stat_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RANGE  = 8'b0000_0010,
    S_TOTAL  = 8'b0000_0100,
    S_DINIT  = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_COMMIT = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/mmc_if.sv
// sample and result channel interfaces
`default_nettype none

interface mmc_smp_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;
  logic    last;

  modport source (output valid, op, sample_x, sample_y, sample_z, last, input ready);
  modport sink   (input valid, op, sample_x, sample_y, sample_z, last, output ready);
endinterface

interface mmc_res_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  sample_t value_x;
  sample_t value_y;
  sample_t value_z;
  gain_t   gain_x;
  gain_t   gain_y;
  gain_t   gain_z;
  logic    error;

  modport source (output valid, kind, value_x, value_y, value_z, gain_x, gain_y, gain_z,
                  error, input ready);
  modport sink   (input valid, kind, value_x, value_y, value_z, gain_x, gain_y, gain_z,
                  error, output ready);
endinterface

`default_nettype wire

// File: rtl/mmc_lane.sv
// one axis: min/max tracking, offset, serial scale divider, correction multiply
`default_nettype none

module mmc_lane import mmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  input  total_t     total,
  output lane_stat_t stat
);

  sample_t                       min_v;
  sample_t                       max_v;
  sample_t                       off;
  gain_t                         scale;
  range_t                        rng;
  logic [DEN_BITS-1:0]           den;
  logic [DEN_BITS-1:0]           rem;
  gain_t                         quo;
  gain_t                         dlow;
  logic                          ovf;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [PROD_BITS-1:0]   prod;

  logic signed [DIFF_BITS-1:0]   span;
  logic signed [DIFF_BITS-1:0]   sum2;
  logic [DVD_BITS-1:0]           dvd;
  logic [DEN_BITS-1:0]           den_new;
  logic                          ovf_new;
  logic [DEN_BITS:0]             trial;
  logic [DEN_BITS:0]             trial_sub;
  logic                          trial_ge;
  logic signed [SHR_BITS-1:0]    shr;
  logic [SHR_BITS-SAMPLE_BITS:0] shr_hi;
  logic                          pos_ovf;
  logic                          neg_ovf;

  assign span = {max_v[SAMPLE_BITS-1], max_v} - {min_v[SAMPLE_BITS-1], min_v};
  assign sum2 = {max_v[SAMPLE_BITS-1], max_v} + {min_v[SAMPLE_BITS-1], min_v};

  // divisor is three times the range
  assign dvd     = {total, {SCALE_FRAC_BITS{1'b0}}};
  assign den_new = {2'b00, rng} + {1'b0, rng, 1'b0};
  // quotient would not fit the gain: also catches a zero range
  assign ovf_new = {{(GAIN_BITS-SCALE_FRAC_BITS){1'b0}}, dvd} >= {den_new, {GAIN_BITS{1'b0}}};

  assign trial     = {rem, dlow[GAIN_BITS-1]};
  assign trial_sub = trial - {1'b0, den};
  assign trial_ge  = trial >= {1'b0, den};

  // floor shift of the product, then saturate
  assign shr     = prod[PROD_BITS-1:SCALE_FRAC_BITS];
  assign shr_hi  = shr[SHR_BITS-1:SAMPLE_BITS-1];
  assign pos_ovf = !shr[SHR_BITS-1] && (|shr_hi);
  assign neg_ovf = shr[SHR_BITS-1] && !(&shr_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_v <= SAMPLE_MAX;
      max_v <= SAMPLE_MIN;
      off   <= '0;
      scale <= GAIN_ONE;
    end else begin
      if (ctrl.cal) begin
        if (sample < min_v) min_v <= sample;
        if (sample > max_v) max_v <= sample;
      end
      if (ctrl.rng_load) begin
        off   <= sum2[DIFF_BITS-1:1];
        min_v <= SAMPLE_MAX;
        max_v <= SAMPLE_MIN;
      end
      if (ctrl.scale_load) begin
        scale <= ovf ? GAIN_MAX : quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rng_load) begin
      rng <= span[DIFF_BITS-1] ? '0 : span[SAMPLE_BITS-1:0];
    end
    if (ctrl.div_start) begin
      den  <= den_new;
      ovf  <= ovf_new;
      rem  <= {{(DEN_BITS-DVD_BITS+GAIN_BITS){1'b0}}, dvd[DVD_BITS-1:GAIN_BITS]};
      dlow <= dvd[GAIN_BITS-1:0];
      quo  <= '0;
    end else if (ctrl.div_step) begin
      rem  <= trial_ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      dlow <= {dlow[GAIN_BITS-2:0], 1'b0};
      quo  <= {quo[GAIN_BITS-2:0], trial_ge};
    end
    if (ctrl.apply) begin
      diff <= {sample[SAMPLE_BITS-1], sample} - {off[SAMPLE_BITS-1], off};
    end
    if (ctrl.mul_load) begin
      prod <= diff * $signed({1'b0, scale});
    end
  end

  always_comb begin
    stat.rng      = rng;
    stat.off      = off;
    stat.scale    = scale;
    stat.cal_err  = ovf;
    stat.corr_err = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      stat.corr = SAMPLE_MAX;
    end else if (neg_ovf) begin
      stat.corr = SAMPLE_MIN;
    end else begin
      stat.corr = shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/magnetometer_min_max_calibration.sv
// top level: sequencer, three axis lanes, merge of lane results and result register
// calibration word without last: folded into min/max, ready stays high, no result
// apply word: difference, product and result registered in turn, then ready again
// closing calibration word: range and offset, total, divider load, division, scale, result
//   registered in turn; the per-lane restoring divider gives one scale bit per cycle (16 bits)
// a waiting result does not block the sequencer until its final load into the result register
// rst (synchronous) re-arms min/max, clears offsets, sets unity scales, empties the output
`default_nettype none

module magnetometer_min_max_calibration import mmc_pkg::*; (
  input logic       clk,
  input logic       rst,
  mmc_smp_if.sink   smp,
  mmc_res_if.source res
);

  state_t                  state;
  state_t                  state_next;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    kind_r;
  total_t                  total;

  logic       take;
  logic       load_out;
  lane_ctrl_t ctrl;
  sample_t    lane_in [NUM_AXES];
  lane_stat_t st      [NUM_AXES];

  // result register
  logic    out_valid;
  logic    kind_o;
  sample_t value_o [NUM_AXES];
  gain_t   gain_o  [NUM_AXES];
  logic    error_o;

  // input handshake: one word in flight at a time
  assign smp.ready = (state == S_IDLE);
  assign take      = smp.valid && smp.ready;

  // final load waits only for the result register to free up
  assign load_out  = (state == S_FIN) && (!out_valid || res.ready);

  assign lane_in[0] = smp.sample_x;
  assign lane_in[1] = smp.sample_y;
  assign lane_in[2] = smp.sample_z;

  // controls fan out to all lanes alike
  always_comb begin
    ctrl.cal        = take && (smp.op == OP_CAL);
    ctrl.apply      = take && (smp.op == OP_APPLY);
    ctrl.rng_load   = (state == S_RANGE);
    ctrl.div_start  = (state == S_DINIT);
    ctrl.div_step   = (state == S_DIV);
    ctrl.scale_load = (state == S_COMMIT);
    ctrl.mul_load   = (state == S_MUL);
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    mmc_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .sample(lane_in[i]),
      .total (total),
      .stat  (st[i])
    );
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (smp.op == OP_APPLY) begin
            state_next = S_MUL;
          end else if (smp.last) begin
            state_next = S_RANGE;
          end
        end
      end
      S_RANGE:  state_next = S_TOTAL;
      S_TOTAL:  state_next = S_DINIT;
      S_DINIT:  state_next = S_DIV;
      S_DIV: begin
        if (cnt == '0) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_FIN;
      S_MUL:    state_next = S_FIN;
      S_FIN: begin
        if (load_out) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // merge stage: sum of ranges feeds every divider, errors are or-ed
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= (smp.op == OP_APPLY) ? KIND_CORR : KIND_CAL;
    end
    if (state == S_TOTAL) begin
      total <= {2'b00, st[0].rng} + {2'b00, st[1].rng} + {2'b00, st[2].rng};
    end
    if (state == S_DINIT) begin
      cnt <= DIV_CNT_BITS'(GAIN_BITS - 1);
    end else if (state == S_DIV) begin
      cnt <= cnt - 1'b1;
    end
    if (load_out) begin
      kind_o <= kind_r;
      if (kind_r == KIND_CORR) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          value_o[a] <= st[a].corr;
          gain_o[a]  <= GAIN_ZERO;
        end
        error_o <= st[0].corr_err || st[1].corr_err || st[2].corr_err;
      end else begin
        for (int a = 0; a < NUM_AXES; a++) begin
          value_o[a] <= st[a].off;
          gain_o[a]  <= st[a].scale;
        end
        error_o <= st[0].cal_err || st[1].cal_err || st[2].cal_err;
      end
    end
  end

  assign res.valid   = out_valid;
  assign res.kind    = kind_o;
  assign res.value_x = value_o[0];
  assign res.value_y = value_o[1];
  assign res.value_z = value_o[2];
  assign res.gain_x  = gain_o[0];
  assign res.gain_y  = gain_o[1];
  assign res.gain_z  = gain_o[2];
  assign res.error   = error_o;

endmodule

`default_nettype wire

// File: rtl/mmc_checker.sv
// port-level checks for the calibration block and their binding
`default_nettype none

module mmc_checker import mmc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    smp_valid,
  input logic    smp_ready,
  input logic    smp_op,
  input logic    smp_last,
  input logic    res_valid,
  input logic    res_ready,
  input logic    res_kind,
  input sample_t value_x,
  input sample_t value_y,
  input sample_t value_z,
  input gain_t   gain_x,
  input gain_t   gain_y,
  input gain_t   gain_z,
  input logic    res_error
);

  // stalled result keeps its values, kind and error flag
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value_x) && $stable(value_y)
      && $stable(value_z) && $stable(res_kind) && $stable(res_error))
    else $error("result word changed while stalled");

  // corrected samples carry no gains
  a_corr_gain: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_CORR) |->
      (gain_x == GAIN_ZERO) && (gain_y == GAIN_ZERO) && (gain_z == GAIN_ZERO))
    else $error("gain on corrected sample");

  // calibration error only comes with a saturated scale
  a_cal_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_CAL) && res_error |->
      (gain_x == GAIN_MAX) || (gain_y == GAIN_MAX) || (gain_z == GAIN_MAX))
    else $error("calibration error without saturated scale");

  // closing word keeps the input busy through the division
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready && (smp_op == OP_CAL) && smp_last |-> ##19 !smp_ready)
    else $error("input ready during scale division");

endmodule

bind magnetometer_min_max_calibration mmc_checker u_mmc_checker (
  .clk      (clk),
  .rst      (rst),
  .smp_valid(smp.valid),
  .smp_ready(smp.ready),
  .smp_op   (smp.op),
  .smp_last (smp.last),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_kind (res.kind),
  .value_x  (res.value_x),
  .value_y  (res.value_y),
  .value_z  (res.value_z),
  .gain_x   (res.gain_x),
  .gain_y   (res.gain_y),
  .gain_z   (res.gain_z),
  .res_error(res.error)
);

`default_nettype wire
